>>> design/i2c_target_buffer_fsm_assert.svh
// assertion macros used by the checker file
`ifndef I2C_TARGET_BUFFER_FSM_ASSERT_SVH
`define I2C_TARGET_BUFFER_FSM_ASSERT_SVH

// condition in the same cycle
`define I2CTB_ASSERT_SAME(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);

// condition in the next cycle
`define I2CTB_ASSERT_NEXT(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

>>> design/i2ctb_pkg.sv
// ----------------------------------------------------------------------------
// i2ctb_pkg
// types and constants of the i2c target byte controller
// ----------------------------------------------------------------------------
package i2ctb_pkg;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_START = 3'd1,
        PH_ADDR  = 3'd2,
        PH_TXACK = 3'd3,
        PH_RXACK = 3'd4,
        PH_RX    = 3'd5,
        PH_TX    = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_ACK     = 3'd1,
        ACT_RELEASE = 3'd2,
        ACT_SAMPLE  = 3'd3,
        ACT_SEND    = 3'd4,
        ACT_RECV    = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_BYTE   = 2'd1,
        OP_LOAD   = 2'd2,
        OP_UNUSED = 2'd3
    } op_t;

    localparam logic [2:0] CFG_DEVICE_ADDRESS       = 3'd0;
    localparam logic [2:0] CFG_TX_SIZE              = 3'd1;
    localparam logic [2:0] CFG_MULTI_ADDRESS_ENABLE = 3'd2;
    localparam logic [2:0] CFG_BROADCAST_ADDRESS    = 3'd3;
    localparam logic [2:0] CFG_FLIGHT_OFFSET        = 3'd4;

    localparam logic [7:0] FLIGHT_OFFSET_RESET = 8'h80;
    localparam logic [7:0] ADDR_MASK           = 8'hfe;
    localparam logic [7:0] PAD_BYTE            = 8'h55;
    localparam logic [7:0] RW_BIT              = 8'h01;

endpackage

>>> design/i2c_target_buffer_fsm.sv
// ----------------------------------------------------------------------------
// i2c_target_buffer_fsm
// byte-level state machine of an i2c target with a message buffer
// ----------------------------------------------------------------------------
// pipeline: stage 1, then the output register; one transaction per cycle
//   unless m_tready stalls the output; the buffer ram has one read port
//   and one write port, each used at most once per event
// reset: rst_n async, clears phase, counters, config (flight offset to 0x80);
//   the buffer ram is not cleared and holds garbage until written
module i2c_target_buffer_fsm #(
    parameter int BUF_DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // config write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // scl_high, bus_byte, load_index, load_value
    input  logic [1:0]  s_tuser,  // operation
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,  // tx_byte, message_ready, message_length,
                                  // flight_request, bus_state
    output logic [2:0]  m_tuser   // line_action
);

    localparam int AW   = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int CW   = $clog2(BUF_DEPTH + 1);
    localparam int CMPW = (CW > 6) ? CW : 6;
    localparam int LIW  = (AW > 5) ? AW : 5;
    localparam logic [CW-1:0]   DEPTH_CNT = CW'(BUF_DEPTH);
    localparam logic [CMPW-1:0] DEPTH_CMP = CMPW'(BUF_DEPTH);
    localparam logic [LIW:0]    DEPTH_LI  = (LIW + 1)'(BUF_DEPTH);
    localparam logic [CW-1:0]   CNT_ONE   = CW'(1);

    // input fields
    logic         scl_high;
    logic [7:0]   bus_byte;
    logic [4:0]   load_index;
    logic [7:0]   load_value;
    i2ctb_pkg::op_t operation;

    assign operation  = i2ctb_pkg::op_t'(s_tuser);
    assign scl_high   = s_tdata[0];
    assign bus_byte   = s_tdata[8:1];
    assign load_index = s_tdata[13:9];
    assign load_value = s_tdata[21:14];

    // config registers
    logic [7:0] device_address_reg;
    logic [5:0] tx_size_reg;
    logic       multi_address_enable_reg;
    logic [7:0] broadcast_address_reg;
    logic [7:0] flight_offset_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_address_reg       <= '0;
            tx_size_reg              <= '0;
            multi_address_enable_reg <= 1'b0;
            broadcast_address_reg    <= '0;
            flight_offset_reg        <= i2ctb_pkg::FLIGHT_OFFSET_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                i2ctb_pkg::CFG_DEVICE_ADDRESS:       device_address_reg <= cfg_data;
                i2ctb_pkg::CFG_TX_SIZE:              tx_size_reg <= cfg_data[5:0];
                i2ctb_pkg::CFG_MULTI_ADDRESS_ENABLE: multi_address_enable_reg <= cfg_data[0];
                i2ctb_pkg::CFG_BROADCAST_ADDRESS:    broadcast_address_reg <= cfg_data;
                i2ctb_pkg::CFG_FLIGHT_OFFSET:        flight_offset_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // control state
    i2ctb_pkg::phase_t phase_reg, phase_next;
    logic [7:0]    command_byte_reg, command_byte_next;
    logic [CW-1:0] received_count_reg, received_count_next;
    logic [CW-1:0] sent_count_reg, sent_count_next;

    // pipeline handshake
    logic s1_valid_reg;
    logic out_valid_reg;
    logic out_free;
    logic s1_adv;
    logic accept;

    assign out_free = !out_valid_reg || m_tready;
    assign s1_adv   = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;
    assign accept   = s_tvalid && s_tready;

    // address decode
    logic [7:0] addr_bits;
    logic [8:0] flight_sum;
    logic       own_hit;
    logic       addr_hit;
    logic       is_read;
    logic       flight_hit;
    logic       refuse;
    logic       addr_ok;

    assign addr_bits  = bus_byte & i2ctb_pkg::ADDR_MASK;
    assign flight_sum = {1'b0, device_address_reg} + {1'b0, flight_offset_reg};
    assign own_hit    = (addr_bits == device_address_reg);
    assign addr_hit   = own_hit
                     || (multi_address_enable_reg && (addr_bits == broadcast_address_reg))
                     || (multi_address_enable_reg
                         && (device_address_reg < flight_offset_reg)
                         && ({1'b0, addr_bits} == flight_sum));
    assign is_read    = |(bus_byte & i2ctb_pkg::RW_BIT);
    assign flight_hit = addr_hit && is_read && multi_address_enable_reg && !own_hit;
    assign refuse     = addr_hit && is_read && !flight_hit && (tx_size_reg == '0);
    assign addr_ok    = addr_hit && !refuse;

    // buffer bookkeeping
    logic [CMPW-1:0] sent_cmp;
    logic [CMPW-1:0] tx_size_cmp;
    logic            tx_stop;
    logic            tx_avail;
    logic            rx_room;
    logic [LIW-1:0]  load_index_ext;
    logic            load_ok;
    logic            cmd_read;

    assign sent_cmp       = CMPW'(sent_count_reg);
    assign tx_size_cmp    = CMPW'(tx_size_reg);
    assign tx_stop        = (sent_count_reg != '0) && is_read;
    assign tx_avail       = (sent_cmp < tx_size_cmp) && (sent_cmp < DEPTH_CMP);
    assign rx_room        = received_count_reg < DEPTH_CNT;
    assign load_index_ext = LIW'(load_index);
    assign load_ok        = {1'b0, load_index_ext} < DEPTH_LI;
    assign cmd_read       = |(command_byte_reg & i2ctb_pkg::RW_BIT);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            case (operation)
                i2ctb_pkg::OP_START:
                begin
                    phase_next = scl_high ? i2ctb_pkg::PH_START : i2ctb_pkg::PH_ADDR;
                end
                i2ctb_pkg::OP_BYTE:
                begin
                    case (phase_reg)
                        i2ctb_pkg::PH_START: phase_next = i2ctb_pkg::PH_ADDR;
                        i2ctb_pkg::PH_ADDR:
                        begin
                            if (!addr_ok)
                                phase_next = i2ctb_pkg::PH_IDLE;
                            else
                                phase_next = is_read ? i2ctb_pkg::PH_TXACK
                                                     : i2ctb_pkg::PH_RXACK;
                        end
                        i2ctb_pkg::PH_TXACK:
                        begin
                            phase_next = tx_stop ? i2ctb_pkg::PH_IDLE : i2ctb_pkg::PH_TX;
                        end
                        i2ctb_pkg::PH_RXACK: phase_next = i2ctb_pkg::PH_RX;
                        i2ctb_pkg::PH_RX:
                        begin
                            if (!rx_room)
                                phase_next = i2ctb_pkg::PH_IDLE;
                            else
                                phase_next = cmd_read ? i2ctb_pkg::PH_TXACK
                                                      : i2ctb_pkg::PH_RXACK;
                        end
                        i2ctb_pkg::PH_TX: phase_next = i2ctb_pkg::PH_TXACK;
                        default: phase_next = phase_reg;
                    endcase
                end
                default: phase_next = phase_reg;
            endcase
        end
    end

    // outputs of the event, counters and ram access
    i2ctb_pkg::action_t act;
    logic [7:0]    txb_const;
    logic          use_ram;
    logic          ready;
    logic [CW-1:0] mlen;
    logic          flight;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;

    always_comb
    begin
        act                 = i2ctb_pkg::ACT_NONE;
        txb_const           = '0;
        use_ram             = 1'b0;
        ready               = 1'b0;
        mlen                = '0;
        flight              = 1'b0;
        command_byte_next   = command_byte_reg;
        received_count_next = received_count_reg;
        sent_count_next     = sent_count_reg;
        ram_we              = 1'b0;
        ram_waddr           = received_count_reg[AW-1:0];
        ram_wdata           = bus_byte;
        ram_re              = 1'b0;
        if (accept)
        begin
            case (operation)
                i2ctb_pkg::OP_START:
                begin
                    act = i2ctb_pkg::ACT_RECV;
                    if (received_count_reg != '0)
                    begin
                        ready               = 1'b1;
                        mlen                = received_count_reg;
                        received_count_next = '0;
                    end
                end
                i2ctb_pkg::OP_BYTE:
                begin
                    case (phase_reg)
                        i2ctb_pkg::PH_ADDR:
                        begin
                            flight = flight_hit;
                            if (addr_ok)
                            begin
                                act                 = i2ctb_pkg::ACT_ACK;
                                command_byte_next   = bus_byte;
                                received_count_next = '0;
                                sent_count_next     = '0;
                            end
                            else
                            begin
                                act = i2ctb_pkg::ACT_RELEASE;
                            end
                        end
                        i2ctb_pkg::PH_TXACK:
                        begin
                            if (tx_stop)
                            begin
                                act = i2ctb_pkg::ACT_RELEASE;
                            end
                            else
                            begin
                                act = i2ctb_pkg::ACT_SEND;
                                if (tx_avail)
                                begin
                                    ram_re          = 1'b1;
                                    use_ram         = 1'b1;
                                    sent_count_next = sent_count_reg + CNT_ONE;
                                end
                                else
                                begin
                                    txb_const = i2ctb_pkg::PAD_BYTE;
                                end
                            end
                        end
                        i2ctb_pkg::PH_RXACK: act = i2ctb_pkg::ACT_RECV;
                        i2ctb_pkg::PH_RX:
                        begin
                            if (rx_room)
                            begin
                                act                 = i2ctb_pkg::ACT_ACK;
                                ram_we              = 1'b1;
                                received_count_next = received_count_reg + CNT_ONE;
                            end
                            else
                            begin
                                act = i2ctb_pkg::ACT_RELEASE;
                            end
                        end
                        i2ctb_pkg::PH_TX: act = i2ctb_pkg::ACT_SAMPLE;
                        default: act = i2ctb_pkg::ACT_NONE;
                    endcase
                end
                i2ctb_pkg::OP_LOAD:
                begin
                    ram_we    = load_ok;
                    ram_waddr = load_index_ext[AW-1:0];
                    ram_wdata = load_value;
                end
                default: act = i2ctb_pkg::ACT_NONE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= i2ctb_pkg::PH_IDLE;
            command_byte_reg   <= '0;
            received_count_reg <= '0;
            sent_count_reg     <= '0;
        end
        else
        begin
            phase_reg          <= phase_next;
            command_byte_reg   <= command_byte_next;
            received_count_reg <= received_count_next;
            sent_count_reg     <= sent_count_next;
        end
    end

    // buffer ram, one write and one registered read port
    logic [7:0] buf_mem [BUF_DEPTH];
    logic [7:0] ram_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ram_we)
            buf_mem[ram_waddr] <= ram_wdata;
        if (ram_re)
            ram_rdata_reg <= buf_mem[sent_count_reg[AW-1:0]];
    end

    // stage 1: waits for the ram read data
    i2ctb_pkg::action_t s1_act_reg;
    logic [7:0]    s1_txb_reg;
    logic          s1_use_ram_reg;
    logic          s1_ready_reg;
    logic [5:0]    s1_mlen_reg;
    logic          s1_flight_reg;
    i2ctb_pkg::phase_t s1_state_reg;
    logic [CMPW-1:0]   mlen_ext;

    assign mlen_ext = CMPW'(mlen);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept)
            s1_valid_reg <= 1'b1;
        else if (s1_adv)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_act_reg     <= act;
            s1_txb_reg     <= txb_const;
            s1_use_ram_reg <= use_ram;
            s1_ready_reg   <= ready;
            s1_mlen_reg    <= mlen_ext[5:0];
            s1_flight_reg  <= flight;
            s1_state_reg   <= phase_next;
        end
    end

    // output register
    logic [2:0]  out_user_reg;
    logic [23:0] out_data_reg;
    logic [7:0]  s1_tx_byte;

    assign s1_tx_byte = s1_use_ram_reg ? ram_rdata_reg : s1_txb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_adv)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_user_reg <= s1_act_reg;
            out_data_reg <= {5'd0, s1_state_reg, s1_flight_reg, s1_mlen_reg,
                             s1_ready_reg, s1_tx_byte};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

>>> design/i2ctb_checker.sv
// ----------------------------------------------------------------------------
// i2ctb_checker
// port-level checks of the i2c target byte controller
// ----------------------------------------------------------------------------
`include "i2c_target_buffer_fsm_assert.svh"

module i2ctb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [2:0]  m_tuser
);

    logic [2:0] line_action;
    logic [7:0] tx_byte;
    logic       message_ready;
    logic [5:0] message_length;
    logic       flight_request;
    logic [2:0] bus_state;

    assign line_action    = m_tuser;
    assign tx_byte        = m_tdata[7:0];
    assign message_ready  = m_tdata[8];
    assign message_length = m_tdata[14:9];
    assign flight_request = m_tdata[15];
    assign bus_state      = m_tdata[18:16];

    // stalled result holds
    `I2CTB_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // a completed message is only reported on a start
    `I2CTB_ASSERT_SAME(a_ready_on_start, clk, rst_n, m_tvalid && message_ready, line_action == i2ctb_pkg::ACT_RECV && message_length != 6'd0, "message_ready outside a start")

    // only a send carries a data byte
    `I2CTB_ASSERT_SAME(a_txbyte_on_send, clk, rst_n, m_tvalid && tx_byte != 8'd0, line_action == i2ctb_pkg::ACT_SEND && bus_state == i2ctb_pkg::PH_TX, "tx_byte without send")

    // flight request only on an acked read address
    `I2CTB_ASSERT_SAME(a_flight_ack, clk, rst_n, m_tvalid && flight_request, line_action == i2ctb_pkg::ACT_ACK && bus_state == i2ctb_pkg::PH_TXACK, "flight_request without read ack")

    // release always drops back to idle
    `I2CTB_ASSERT_SAME(a_release_idle, clk, rst_n, m_tvalid && line_action == i2ctb_pkg::ACT_RELEASE, bus_state == i2ctb_pkg::PH_IDLE, "release without idle")

endmodule

bind i2c_target_buffer_fsm i2ctb_checker u_i2ctb_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> dv/tb_i2c_target_buffer_fsm.sv
// ----------------------------------------------------------------------------
// tb_i2c_target_buffer_fsm
// self-checking bench for the i2c target byte controller
// ----------------------------------------------------------------------------
// Bus events go in on the input stream and are checked against a predictor
// that mirrors the byte state machine, its config and its message buffer.
// Directed tests cover start handling, address matching, read padding,
// multi-address mode and buffer overflow. Random bus transactions follow
// under several configs, with random stalls on both sides of the block.
// ----------------------------------------------------------------------------
module tb_i2c_target_buffer_fsm;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BUF_DEPTH = 32;

    typedef struct {
        i2ctb_pkg::action_t act;
        logic [7:0]         tx_byte;
        logic               msg_ready;
        logic [5:0]         msg_len;
        logic               flight;
        i2ctb_pkg::phase_t  ph;
    } bus_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;   // scl_high, bus_byte, load_index, load_value
    logic [1:0]  s_tuser = '0;   // operation
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;        // tx_byte, message_ready, message_length,
                                 // flight_request, bus_state
    logic [2:0]  m_tuser;        // line_action

    // predictor state
    i2ctb_pkg::phase_t fsm_phase;
    logic [7:0]  cmd_byte;
    logic [5:0]  rx_count;
    logic [5:0]  tx_count;
    logic [7:0]  shadow_buffer [BUF_DEPTH];
    logic [7:0]  own_addr;
    logic [5:0]  read_size;
    logic        multi_en;
    logic [7:0]  bcast_addr;
    logic [7:0]  flight_off;

    bus_result_t pending_bus_results [$];
    bus_result_t oldest;
    int          mismatch_count = 0;
    int          result_count = 0;
    int          items_accepted = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    i2c_target_buffer_fsm #(
        .BUF_DEPTH (BUF_DEPTH)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic bus_result_t predict_bus_event(input i2ctb_pkg::op_t op,
                                                      input logic scl,
                                                      input logic [7:0] b,
                                                      input logic [4:0] li,
                                                      input logic [7:0] lv);
        bus_result_t r;
        logic [7:0]  a;
        logic        own;
        logic        hit;
        logic        refuse;
        logic [5:0]  eff_size;
        r.act       = i2ctb_pkg::ACT_NONE;
        r.tx_byte   = '0;
        r.msg_ready = 1'b0;
        r.msg_len   = '0;
        r.flight    = 1'b0;
        eff_size    = (read_size < BUF_DEPTH) ? read_size : 6'(BUF_DEPTH);
        case (op)
            i2ctb_pkg::OP_START:
            begin
                if (rx_count != 0)
                begin
                    r.msg_ready = 1'b1;
                    r.msg_len   = rx_count;
                    rx_count    = '0;
                end
                fsm_phase = scl ? i2ctb_pkg::PH_START : i2ctb_pkg::PH_ADDR;
                r.act     = i2ctb_pkg::ACT_RECV;
            end
            i2ctb_pkg::OP_BYTE:
            begin
                case (fsm_phase)
                    i2ctb_pkg::PH_START:
                        fsm_phase = i2ctb_pkg::PH_ADDR;
                    i2ctb_pkg::PH_ADDR:
                    begin
                        a      = b & i2ctb_pkg::ADDR_MASK;
                        own    = (a == own_addr);
                        hit    = own;
                        refuse = 1'b0;
                        if (multi_en)
                        begin
                            if (a == bcast_addr)
                                hit = 1'b1;
                            // sum compared at nine bits, an overflowing sum never matches
                            if (own_addr < flight_off &&
                                {1'b0, a} == {1'b0, own_addr} + {1'b0, flight_off})
                                hit = 1'b1;
                        end
                        if (hit && (b & i2ctb_pkg::RW_BIT) != 0)
                        begin
                            if (multi_en && !own)
                                r.flight = 1'b1;
                            else if (read_size == 0)
                                refuse = 1'b1;
                        end
                        if (!hit || refuse)
                        begin
                            r.act     = i2ctb_pkg::ACT_RELEASE;
                            fsm_phase = i2ctb_pkg::PH_IDLE;
                        end
                        else
                        begin
                            cmd_byte  = b;
                            rx_count  = '0;
                            tx_count  = '0;
                            r.act     = i2ctb_pkg::ACT_ACK;
                            fsm_phase = b[0] ? i2ctb_pkg::PH_TXACK : i2ctb_pkg::PH_RXACK;
                        end
                    end
                    i2ctb_pkg::PH_TXACK:
                    begin
                        // master nack ends the read, except before the first byte
                        if (tx_count != 0 && b[0])
                        begin
                            r.act     = i2ctb_pkg::ACT_RELEASE;
                            fsm_phase = i2ctb_pkg::PH_IDLE;
                        end
                        else
                        begin
                            if (tx_count < eff_size)
                            begin
                                r.tx_byte = shadow_buffer[tx_count[4:0]];
                                tx_count  = tx_count + 6'd1;
                            end
                            else
                                r.tx_byte = i2ctb_pkg::PAD_BYTE;
                            r.act     = i2ctb_pkg::ACT_SEND;
                            fsm_phase = i2ctb_pkg::PH_TX;
                        end
                    end
                    i2ctb_pkg::PH_RXACK:
                    begin
                        r.act     = i2ctb_pkg::ACT_RECV;
                        fsm_phase = i2ctb_pkg::PH_RX;
                    end
                    i2ctb_pkg::PH_RX:
                    begin
                        if (rx_count < BUF_DEPTH)
                        begin
                            shadow_buffer[rx_count[4:0]] = b;
                            rx_count  = rx_count + 6'd1;
                            r.act     = i2ctb_pkg::ACT_ACK;
                            fsm_phase = cmd_byte[0] ? i2ctb_pkg::PH_TXACK
                                                    : i2ctb_pkg::PH_RXACK;
                        end
                        else
                        begin
                            r.act     = i2ctb_pkg::ACT_RELEASE;
                            fsm_phase = i2ctb_pkg::PH_IDLE;
                        end
                    end
                    i2ctb_pkg::PH_TX:
                    begin
                        r.act     = i2ctb_pkg::ACT_SAMPLE;
                        fsm_phase = i2ctb_pkg::PH_TXACK;
                    end
                    default:
                        ;
                endcase
            end
            i2ctb_pkg::OP_LOAD:
                shadow_buffer[li] = lv;
            default:
                ;
        endcase
        r.ph = fsm_phase;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("mismatch at result %0d: %s got %0h expected %0h",
                 result_count, what, got, want);
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            result_count++;
            if (pending_bus_results.size() == 0)
                report_mismatch("result with nothing pending", m_tuser, 0);
            else
            begin
                oldest = pending_bus_results.pop_front();
                if (m_tuser !== oldest.act)
                    report_mismatch("line_action", m_tuser, oldest.act);
                if (m_tdata[7:0] !== oldest.tx_byte)
                    report_mismatch("tx_byte", m_tdata[7:0], oldest.tx_byte);
                if (m_tdata[8] !== oldest.msg_ready)
                    report_mismatch("message_ready", m_tdata[8], oldest.msg_ready);
                if (m_tdata[14:9] !== oldest.msg_len)
                    report_mismatch("message_length", m_tdata[14:9], oldest.msg_len);
                if (m_tdata[15] !== oldest.flight)
                    report_mismatch("flight_request", m_tdata[15], oldest.flight);
                if (m_tdata[18:16] !== oldest.ph)
                    report_mismatch("bus_state", m_tdata[18:16], oldest.ph);
            end
        end
    end

    // one input transaction, with a random gap before it
    task automatic send_event(input i2ctb_pkg::op_t op, input logic scl,
                              input logic [7:0] b, input logic [4:0] li,
                              input logic [7:0] lv);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, lv, li, b, scl};
        do
            @(posedge clk);
        while (!s_tready);
        items_accepted++;
        pending_bus_results.push_back(predict_bus_event(op, scl, b, li, lv));
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_bus_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(input logic [7:0] dev, input logic [7:0] size,
                              input logic multi, input logic [7:0] bcast,
                              input logic [7:0] off);
        wait_for_results();
        cfg_we    <= 1'b1;
        cfg_index <= i2ctb_pkg::CFG_DEVICE_ADDRESS;
        cfg_data  <= dev;
        @(posedge clk);
        cfg_index <= i2ctb_pkg::CFG_TX_SIZE;
        cfg_data  <= size;
        @(posedge clk);
        cfg_index <= i2ctb_pkg::CFG_MULTI_ADDRESS_ENABLE;
        cfg_data  <= {7'b0, multi};
        @(posedge clk);
        cfg_index <= i2ctb_pkg::CFG_BROADCAST_ADDRESS;
        cfg_data  <= bcast;
        @(posedge clk);
        cfg_index <= i2ctb_pkg::CFG_FLIGHT_OFFSET;
        cfg_data  <= off;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        own_addr   = dev;
        read_size  = size[5:0];
        multi_en   = multi;
        bcast_addr = bcast;
        flight_off = off;
    endtask

    // every entry written once so later reads never hit garbage
    task automatic test_buffer_fill();
        for (int i = 0; i < BUF_DEPTH; i++)
            send_event(i2ctb_pkg::OP_LOAD, 1'b0, 8'h00, 5'(i), 8'($urandom));
    endtask

    task automatic test_bus_events();
        send_event(i2ctb_pkg::OP_BYTE, 1'b1, 8'hff, 5'd0, 8'h00);      // byte while idle
        send_event(i2ctb_pkg::OP_UNUSED, 1'b1, 8'hff, 5'h1f, 8'hff);
        send_event(i2ctb_pkg::OP_START, 1'b1, 8'h00, 5'd0, 8'h00);
        send_event(i2ctb_pkg::OP_BYTE, 1'b0, 8'h00, 5'd0, 8'h00);      // leaves start phase
        send_event(i2ctb_pkg::OP_BYTE, 1'b0, 8'h01, 5'd0, 8'h00);      // read refused
        send_event(i2ctb_pkg::OP_START, 1'b0, 8'h00, 5'd0, 8'h00);
        send_event(i2ctb_pkg::OP_BYTE, 1'b0, 8'h00, 5'd0, 8'h00);      // own write
        send_event(i2ctb_pkg::OP_BYTE, 1'b0, 8'h00, 5'd0, 8'h00);
        send_event(i2ctb_pkg::OP_BYTE, 1'b0, 8'hff, 5'd0, 8'h00);
        send_event(i2ctb_pkg::OP_LOAD, 1'b0, 8'h00, 5'h1f, 8'hff);     // load mid message
        send_event(i2ctb_pkg::OP_START, 1'b0, 8'h00, 5'd0, 8'h00);     // message ready
        send_event(i2ctb_pkg::OP_BYTE, 1'b0, 8'hfe, 5'd0, 8'h00);      // no match
    endtask

    task automatic test_read_padding();
        set_config(8'hfe, 8'd2, 1'b0, 8'h00, i2ctb_pkg::FLIGHT_OFFSET_RESET);
        send_event(i2ctb_pkg::OP_START, 1'b0, 8'h00, 5'd0, 8'h00);
        send_event(i2ctb_pkg::OP_BYTE, 1'b0, 8'hff, 5'd0, 8'h00);
        for (int i = 0; i < 3; i++)
        begin
            send_event(i2ctb_pkg::OP_BYTE, 1'b0, 8'h00, 5'd0, 8'h00);
            send_event(i2ctb_pkg::OP_BYTE, 1'b0, 8'hff, 5'd0, 8'h00);
        end
        send_event(i2ctb_pkg::OP_BYTE, 1'b0, 8'h01, 5'd0, 8'h00);      // master nack
    endtask

    task automatic test_multi_address();
        set_config(8'h10, 8'd4, 1'b1, 8'hfe, 8'hfe);
        send_event(i2ctb_pkg::OP_START, 1'b0, 8'h00, 5'd0, 8'h00);
        send_event(i2ctb_pkg::OP_BYTE, 1'b0, 8'hff, 5'd0, 8'h00);      // broadcast read
        send_event(i2ctb_pkg::OP_START, 1'b0, 8'h00, 5'd0, 8'h00);
        send_event(i2ctb_pkg::OP_BYTE, 1'b0, 8'h0f, 5'd0, 8'h00);      // wrapped flight sum
        set_config(8'h10, 8'd0, 1'b1, 8'hfe, 8'h20);
        send_event(i2ctb_pkg::OP_START, 1'b0, 8'h00, 5'd0, 8'h00);
        send_event(i2ctb_pkg::OP_BYTE, 1'b0, 8'h31, 5'd0, 8'h00);      // flight read
        send_event(i2ctb_pkg::OP_START, 1'b0, 8'h00, 5'd0, 8'h00);
        send_event(i2ctb_pkg::OP_BYTE, 1'b0, 8'h11, 5'd0, 8'h00);      // own read, size 0
        set_config(8'h10, 8'd1, 1'b1, 8'h00, 8'h08);
        send_event(i2ctb_pkg::OP_START, 1'b0, 8'h00, 5'd0, 8'h00);
        send_event(i2ctb_pkg::OP_BYTE, 1'b0, 8'h18, 5'd0, 8'h00);      // offset below own
    endtask

    task automatic test_buffer_overflow();
        set_config(8'h20, 8'd32, 1'b0, 8'h00, 8'h00);
        send_event(i2ctb_pkg::OP_START, 1'b0, 8'h00, 5'd0, 8'h00);
        send_event(i2ctb_pkg::OP_BYTE, 1'b0, 8'h20, 5'd0, 8'h00);
        for (int i = 0; i <= BUF_DEPTH; i++)
        begin
            send_event(i2ctb_pkg::OP_BYTE, 1'b0, 8'h00, 5'd0, 8'h00);
            send_event(i2ctb_pkg::OP_BYTE, 1'b0, 8'($urandom), 5'd0, 8'h00);
        end
        send_event(i2ctb_pkg::OP_START, 1'b1, 8'h00, 5'd0, 8'h00);     // full length message
    endtask

    // mostly well formed transactions with random content, some noise
    task automatic run_bus_transaction();
        int         burst;
        int         k;
        logic [7:0] target;
        logic [7:0] b;
        if ($urandom_range(99) < 15)
            send_event(i2ctb_pkg::op_t'($urandom_range(3)), 1'($urandom_range(1)),
                       8'($urandom), 5'($urandom), 8'($urandom));
        else
        begin
            send_event(i2ctb_pkg::OP_START, 1'($urandom_range(1)), 8'($urandom),
                       5'($urandom), 8'($urandom));
            if (fsm_phase == i2ctb_pkg::PH_START)
                send_event(i2ctb_pkg::OP_BYTE, 1'($urandom_range(1)), 8'($urandom),
                           5'($urandom), 8'($urandom));
            case ($urandom_range(4))
                0, 1:    target = own_addr;
                2:       target = bcast_addr;
                3:       target = own_addr + flight_off;
                default: target = 8'($urandom);
            endcase
            send_event(i2ctb_pkg::OP_BYTE, 1'($urandom_range(1)),
                       {target[7:1], 1'($urandom_range(1))}, 5'($urandom), 8'($urandom));
            burst = ($urandom_range(9) == 0) ? $urandom_range(40, 31) : $urandom_range(8);
            k = 0;
            while (fsm_phase != i2ctb_pkg::PH_IDLE && k < 2 * burst + 2)
            begin
                if ($urandom_range(9) == 0)
                    send_event(i2ctb_pkg::OP_LOAD, 1'($urandom_range(1)), 8'($urandom),
                               5'($urandom), 8'($urandom));
                else
                begin
                    b = 8'($urandom);
                    if (fsm_phase == i2ctb_pkg::PH_TXACK)
                        b[0] = (k >= 2 * burst) || ($urandom_range(19) == 0);
                    send_event(i2ctb_pkg::OP_BYTE, 1'($urandom_range(1)), b, 5'($urandom),
                               8'($urandom));
                    k++;
                end
            end
        end
    endtask

    task automatic test_random();
        int         phase_start;
        logic [7:0] dev;
        logic [7:0] size;
        logic [7:0] bcast;
        logic [7:0] off;
        for (int seg = 0; seg < 3; seg++)
        begin
            send_idle_pct = (seg == 0) ? 23 : (seg == 1) ? 73 : 0;
            recv_idle_pct = (seg == 0) ? 73 : (seg == 1) ? 23 : 0;
            for (int n = 0; n < 4; n++)
            begin
                case ($urandom_range(3))
                    0:       dev = 8'h00;
                    1:       dev = 8'hfe;
                    2:       dev = 8'($urandom_range(127) * 2);
                    default: dev = 8'($urandom_range(254));
                endcase
                case ($urandom_range(3))
                    0:       size = 8'd0;
                    1:       size = 8'd32;
                    2:       size = 8'd1;
                    default: size = 8'($urandom_range(32));
                endcase
                case ($urandom_range(2))
                    0:       bcast = 8'h00;
                    1:       bcast = 8'hfe;
                    default: bcast = 8'($urandom_range(254));
                endcase
                case ($urandom_range(3))
                    0:       off = 8'h00;
                    1:       off = 8'hfe;
                    2:       off = i2ctb_pkg::FLIGHT_OFFSET_RESET;
                    default: off = 8'($urandom_range(254));
                endcase
                set_config(dev, size, 1'($urandom_range(1)), bcast, off);
                phase_start = items_accepted;
                while (items_accepted - phase_start < 85)
                    run_bus_transaction();
            end
        end
    endtask

    initial
    begin
        fsm_phase  = i2ctb_pkg::PH_IDLE;
        cmd_byte   = '0;
        rx_count   = '0;
        tx_count   = '0;
        own_addr   = '0;
        read_size  = '0;
        multi_en   = 1'b0;
        bcast_addr = '0;
        flight_off = i2ctb_pkg::FLIGHT_OFFSET_RESET;
        send_idle_pct = 23;
        recv_idle_pct = 73;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_buffer_fill();
        test_bus_events();
        test_read_padding();
        test_multi_address();
        test_buffer_overflow();
        test_random();
        wait_for_results();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("** i2c_target_buffer_fsm: PASSED **");
        else
            $display("** i2c_target_buffer_fsm: FAILED **");
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("** i2c_target_buffer_fsm: FAILED **");
        $finish;
    end

endmodule
